### sv/qvr_pkg.sv
// Shared types and constants of the quaternion vertex rotation block.
package qvr_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int QUAT_WIDTH_DEF = 16;
	localparam int CFG_ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_ROT_X = 2'd0,
		REG_ROT_Y = 2'd1,
		REG_ROT_Z = 2'd2,
		REG_ROT_W = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} qvr_adv_t;

endpackage

### sv/qvr_datapath.sv
// Arithmetic pipeline: both Hamilton products, rounding and saturation.
module qvr_datapath
	import qvr_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int QUAT_WIDTH = QUAT_WIDTH_DEF
) (
	input  logic                          clk,
	input  qvr_adv_t                      adv,
	input  logic signed [QUAT_WIDTH-1:0]  qx,
	input  logic signed [QUAT_WIDTH-1:0]  qy,
	input  logic signed [QUAT_WIDTH-1:0]  qz,
	input  logic signed [QUAT_WIDTH-1:0]  qw,
	input  logic signed [COORD_WIDTH-1:0] vx,
	input  logic signed [COORD_WIDTH-1:0] vy,
	input  logic signed [COORD_WIDTH-1:0] vz,
	output logic signed [COORD_WIDTH-1:0] rx,
	output logic signed [COORD_WIDTH-1:0] ry,
	output logic signed [COORD_WIDTH-1:0] rz
);

	localparam int P1W = COORD_WIDTH + QUAT_WIDTH;
	localparam int TW = P1W + 2;
	localparam int P3W = TW + QUAT_WIDTH;
	localparam int AW = P3W + 3;
	localparam int FRAC = 2 * (QUAT_WIDTH - 2);
	localparam logic signed [AW-1:0] RND = AW'(1) << (FRAC - 1);
	localparam logic signed [AW-1:0] SAT_MAX = {{(AW - COORD_WIDTH + 1){1'b0}},
		{(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [AW-1:0] SAT_MIN = ~SAT_MAX;

	logic signed [P1W-1:0] p_wx_s1, p_wy_s1, p_wz_s1;
	logic signed [P1W-1:0] p_xx_s1, p_xy_s1, p_xz_s1;
	logic signed [P1W-1:0] p_yx_s1, p_yy_s1, p_yz_s1;
	logic signed [P1W-1:0] p_zx_s1, p_zy_s1, p_zz_s1;

	logic signed [TW-1:0] tx_s2, ty_s2, tz_s2, tw_s2;

	logic signed [P3W-1:0] m_wx_s3, m_wy_s3, m_wz_s3;
	logic signed [P3W-1:0] m_xw_s3, m_xy_s3, m_xz_s3;
	logic signed [P3W-1:0] m_yw_s3, m_yx_s3, m_yz_s3;
	logic signed [P3W-1:0] m_zw_s3, m_zx_s3, m_zy_s3;

	logic signed [AW-1:0] ax_s4, ay_s4, az_s4;
	logic signed [AW-1:0] shx, shy, shz;

	logic signed [COORD_WIDTH-1:0] rx_s5, ry_s5, rz_s5;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			p_wx_s1 <= P1W'(qw) * P1W'(vx);
			p_wy_s1 <= P1W'(qw) * P1W'(vy);
			p_wz_s1 <= P1W'(qw) * P1W'(vz);
			p_xx_s1 <= P1W'(qx) * P1W'(vx);
			p_xy_s1 <= P1W'(qx) * P1W'(vy);
			p_xz_s1 <= P1W'(qx) * P1W'(vz);
			p_yx_s1 <= P1W'(qy) * P1W'(vx);
			p_yy_s1 <= P1W'(qy) * P1W'(vy);
			p_yz_s1 <= P1W'(qy) * P1W'(vz);
			p_zx_s1 <= P1W'(qz) * P1W'(vx);
			p_zy_s1 <= P1W'(qz) * P1W'(vy);
			p_zz_s1 <= P1W'(qz) * P1W'(vz);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			tx_s2 <= TW'(p_wx_s1) + TW'(p_yz_s1) - TW'(p_zy_s1);
			ty_s2 <= TW'(p_wy_s1) - TW'(p_xz_s1) + TW'(p_zx_s1);
			tz_s2 <= TW'(p_wz_s1) + TW'(p_xy_s1) - TW'(p_yx_s1);
			tw_s2 <= -(TW'(p_xx_s1) + TW'(p_yy_s1) + TW'(p_zz_s1));
		end
	end

	// Second product against the conjugate; the signs of the negated vector part
	// are folded into the sums of the next stage.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			m_wx_s3 <= P3W'(tw_s2) * P3W'(qx);
			m_wy_s3 <= P3W'(tw_s2) * P3W'(qy);
			m_wz_s3 <= P3W'(tw_s2) * P3W'(qz);
			m_xw_s3 <= P3W'(tx_s2) * P3W'(qw);
			m_xy_s3 <= P3W'(tx_s2) * P3W'(qy);
			m_xz_s3 <= P3W'(tx_s2) * P3W'(qz);
			m_yw_s3 <= P3W'(ty_s2) * P3W'(qw);
			m_yx_s3 <= P3W'(ty_s2) * P3W'(qx);
			m_yz_s3 <= P3W'(ty_s2) * P3W'(qz);
			m_zw_s3 <= P3W'(tz_s2) * P3W'(qw);
			m_zx_s3 <= P3W'(tz_s2) * P3W'(qx);
			m_zy_s3 <= P3W'(tz_s2) * P3W'(qy);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			ax_s4 <= AW'(m_xw_s3) - AW'(m_wx_s3) - AW'(m_yz_s3) + AW'(m_zy_s3) + RND;
			ay_s4 <= AW'(m_yw_s3) - AW'(m_wy_s3) + AW'(m_xz_s3) - AW'(m_zx_s3) + RND;
			az_s4 <= AW'(m_zw_s3) - AW'(m_wz_s3) - AW'(m_xy_s3) + AW'(m_yx_s3) + RND;
		end
	end

	assign shx = ax_s4 >>> FRAC;
	assign shy = ay_s4 >>> FRAC;
	assign shz = az_s4 >>> FRAC;

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			rx_s5 <= (shx > SAT_MAX) ? SAT_MAX[COORD_WIDTH-1:0] :
				(shx < SAT_MIN) ? SAT_MIN[COORD_WIDTH-1:0] : shx[COORD_WIDTH-1:0];
			ry_s5 <= (shy > SAT_MAX) ? SAT_MAX[COORD_WIDTH-1:0] :
				(shy < SAT_MIN) ? SAT_MIN[COORD_WIDTH-1:0] : shy[COORD_WIDTH-1:0];
			rz_s5 <= (shz > SAT_MAX) ? SAT_MAX[COORD_WIDTH-1:0] :
				(shz < SAT_MIN) ? SAT_MIN[COORD_WIDTH-1:0] : shz[COORD_WIDTH-1:0];
		end
	end

	assign rx = rx_s5;
	assign ry = ry_s5;
	assign rz = rz_s5;

endmodule

### sv/quaternion_vertex_rotate_top.sv
// Top level of the quaternion vertex rotation block: stream ports, registers, flow control.
//
// Each input word carries one vertex and gives one output word, the vertex rotated by
// the quaternion held in the registers (identity after reset) and saturated to the
// coordinate range. The block takes one word per clock cycle while the output is not
// stalled; a word passes in order through the stages of the arithmetic pipeline (first
// product, its sums, second product, its sums with rounding, and saturation into the
// output register). Every stage holds its word while the output is stalled, and empty
// stages keep taking input. Rotation registers should be written only while no word is
// in flight.
module quaternion_vertex_rotate_top
	import qvr_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int QUAT_WIDTH = QUAT_WIDTH_DEF,
	localparam int TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_W-1:0]    s_tdata,   // vertex_x, vertex_y, vertex_z, zero fill
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,   // out_x, out_y, out_z, zero fill
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [QUAT_WIDTH-1:0] rot_x_q, rot_y_q, rot_z_q, rot_w_q;
	logic                  cfg_wr;
	reg_idx_t              reg_idx;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	qvr_adv_t adv;

	logic signed [COORD_WIDTH-1:0] rx, ry, rz;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q <= '0;
			rot_y_q <= '0;
			rot_z_q <= '0;
			rot_w_q <= QUAT_WIDTH'(1) << (QUAT_WIDTH - 2);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ROT_X: rot_x_q <= pwdata[QUAT_WIDTH-1:0];
				REG_ROT_Y: rot_y_q <= pwdata[QUAT_WIDTH-1:0];
				REG_ROT_Z: rot_z_q <= pwdata[QUAT_WIDTH-1:0];
				REG_ROT_W: rot_w_q <= pwdata[QUAT_WIDTH-1:0];
				default:   rot_w_q <= rot_w_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROT_X: prdata = 32'(rot_x_q);
			REG_ROT_Y: prdata = 32'(rot_y_q);
			REG_ROT_Z: prdata = 32'(rot_z_q);
			REG_ROT_W: prdata = 32'(rot_w_q);
			default:   prdata = '0;
		endcase
	end

	// A stage may load when it is empty or when the stage after it moves on.
	assign rdy5 = !v_s5 || m_tready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign adv.s1 = rdy1;
	assign adv.s2 = rdy2;
	assign adv.s3 = rdy3;
	assign adv.s4 = rdy4;
	assign adv.s5 = rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	assign s_tready = rdy1;
	assign m_tvalid = v_s5;

	qvr_datapath #(
		.COORD_WIDTH(COORD_WIDTH),
		.QUAT_WIDTH (QUAT_WIDTH)
	) u_datapath (
		.clk(clk),
		.adv(adv),
		.qx (rot_x_q),
		.qy (rot_y_q),
		.qz (rot_z_q),
		.qw (rot_w_q),
		.vx (s_tdata[COORD_WIDTH-1:0]),
		.vy (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.vz (s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
		.rx (rx),
		.ry (ry),
		.rz (rz)
	);

	assign m_tdata = TDATA_W'({rz, ry, rx});

`ifndef NO_ASSERTIONS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("input not ready while the first stage is empty");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted word did not reach the first stage");

	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s4))
		else $error("output word appeared without a word in the rounding stage");

	a_cfg_rot_w: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && (reg_idx == REG_ROT_W) |=> rot_w_q == $past(pwdata[QUAT_WIDTH-1:0]))
		else $error("rotation scalar register write lost");
`endif

endmodule
